@@ rtl/core/palette_gradient_color_map_core_macros.svh @@
// Assertion helpers for the palette gradient color map core
`ifndef PALETTE_GRADIENT_COLOR_MAP_CORE_MACROS_SVH
`define PALETTE_GRADIENT_COLOR_MAP_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PGCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define PGCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PGCM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PGCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/pgcm_pkg.sv @@
`default_nettype none

package pgcm_pkg;

   localparam int POS_WIDTH         = 18;
   localparam int PAL_WIDTH         = 3;
   localparam int CHAN_WIDTH        = 8;
   localparam int IDX_WIDTH         = 3;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Palette codes
   localparam logic [PAL_WIDTH-1:0] PAL_RED     = 3'd0;
   localparam logic [PAL_WIDTH-1:0] PAL_BLUE    = 3'd1;
   localparam logic [PAL_WIDTH-1:0] PAL_ORANGE  = 3'd2;
   localparam logic [PAL_WIDTH-1:0] PAL_GREEN   = 3'd3;
   localparam logic [PAL_WIDTH-1:0] PAL_PURPLE  = 3'd4;
   localparam logic [PAL_WIDTH-1:0] PAL_RAINBOW = 3'd5;

   // Stage enables handed to the per-channel blend pipeline
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } pgcm_adv_type;

   // Map unused codes onto the red palette
   function automatic logic [PAL_WIDTH-1:0] pal_resolve(input logic [PAL_WIDTH-1:0] pal);
      logic [PAL_WIDTH-1:0] res;
      case (pal)
         PAL_RED, PAL_BLUE, PAL_ORANGE, PAL_GREEN, PAL_PURPLE, PAL_RAINBOW: res = pal;
         default: res = PAL_RED;
      endcase
      return res;
   endfunction

   // Index of the last stop (stop count minus one)
   function automatic logic [IDX_WIDTH-1:0] pal_last(input logic [PAL_WIDTH-1:0] pal);
      logic [IDX_WIDTH-1:0] res;
      case (pal)
         PAL_RAINBOW: res = 3'd5;
         default:     res = 3'd2;
      endcase
      return res;
   endfunction

   // Stop color as {red, green, blue}
   function automatic logic [3*CHAN_WIDTH-1:0] stop_color(input logic [PAL_WIDTH-1:0] pal,
                                                           input logic [IDX_WIDTH-1:0] idx);
      logic [3*CHAN_WIDTH-1:0] res;
      res = '0;
      case (pal)
         PAL_BLUE: begin
            case (idx)
               3'd0:    res = {8'd40, 8'd60, 8'd200};
               3'd1:    res = {8'd60, 8'd120, 8'd255};
               default: res = {8'd20, 8'd30, 8'd140};
            endcase
         end
         PAL_ORANGE: begin
            case (idx)
               3'd0:    res = {8'd255, 8'd120, 8'd40};
               3'd1:    res = {8'd255, 8'd160, 8'd60};
               default: res = {8'd220, 8'd90, 8'd20};
            endcase
         end
         PAL_GREEN: begin
            case (idx)
               3'd0:    res = {8'd30, 8'd180, 8'd90};
               3'd1:    res = {8'd60, 8'd220, 8'd140};
               default: res = {8'd20, 8'd120, 8'd60};
            endcase
         end
         PAL_PURPLE: begin
            case (idx)
               3'd0:    res = {8'd160, 8'd60, 8'd220};
               3'd1:    res = {8'd200, 8'd120, 8'd255};
               default: res = {8'd100, 8'd40, 8'd180};
            endcase
         end
         PAL_RAINBOW: begin
            case (idx)
               3'd0:    res = {8'd255, 8'd50, 8'd50};
               3'd1:    res = {8'd255, 8'd150, 8'd50};
               3'd2:    res = {8'd255, 8'd255, 8'd50};
               3'd3:    res = {8'd50, 8'd255, 8'd50};
               3'd4:    res = {8'd50, 8'd150, 8'd255};
               default: res = {8'd160, 8'd50, 8'd255};
            endcase
         end
         default: begin
            case (idx)
               3'd0:    res = {8'd220, 8'd40, 8'd50};
               3'd1:    res = {8'd255, 8'd60, 8'd60};
               default: res = {8'd200, 8'd20, 8'd30};
            endcase
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/pgcm_lerp.sv @@
`default_nettype none

// One color channel: weight both stops, then sum, round and narrow
module pgcm_lerp #(
   parameter int FRAC_BITS = pgcm_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire pgcm_pkg::pgcm_adv_type          adv,
   input  wire logic [pgcm_pkg::CHAN_WIDTH-1:0] stop_a,
   input  wire logic [pgcm_pkg::CHAN_WIDTH-1:0] stop_b,
   input  wire logic [FRAC_BITS-1:0]            frac,
   output logic      [pgcm_pkg::CHAN_WIDTH-1:0] chan
);
   import pgcm_pkg::*;

   localparam int WA_WIDTH  = FRAC_BITS + 1;
   localparam int PA_WIDTH  = CHAN_WIDTH + WA_WIDTH;
   localparam int PB_WIDTH  = CHAN_WIDTH + FRAC_BITS;
   localparam int SUM_WIDTH = CHAN_WIDTH + FRAC_BITS + 1;

   logic [WA_WIDTH-1:0]   weight_a;
   logic [PA_WIDTH-1:0]   prod_a_in, prod_a_ff;
   logic [PB_WIDTH-1:0]   prod_b_in, prod_b_ff;
   logic [SUM_WIDTH-1:0]  sum;
   logic [CHAN_WIDTH-1:0] chan_in, chan_ff;

   // Weight each stop by its share of the fraction
   always_comb begin
      weight_a  = (WA_WIDTH'(1) << FRAC_BITS) - WA_WIDTH'(frac);
      prod_a_in = PA_WIDTH'(stop_a) * PA_WIDTH'(weight_a);
      prod_b_in = PB_WIDTH'(stop_b) * PB_WIDTH'(frac);
   end

   // Add the products with a half for round half up, keep the integer part
   always_comb begin
      sum = SUM_WIDTH'(prod_a_ff) + SUM_WIDTH'(prod_b_ff)
            + (SUM_WIDTH'(1) << (FRAC_BITS - 1));
      chan_in = sum[FRAC_BITS +: CHAN_WIDTH];
   end

   // Advance the two stages
   always_ff @(posedge clock) begin
      if (adv.mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (adv.sum_en) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

@@ rtl/core/palette_gradient_color_map_core.sv @@
// Palette gradient color map core.
// Request channel: req_valid / req_stall with req_position, a signed fixed-point
// position (FRAC_BITS fraction bits) clamped to 0..1.0. Response channel:
// rsp_valid / rsp_stall with rsp_red, rsp_green, rsp_blue. A transaction moves
// at a clock edge with valid high and stall low.
// The palette is written through csr_wr_en / csr_wr_data; write it only while
// no transaction is in flight. Codes 6 and 7 select the red palette.
// From request to response the stages are clamp, scale by the stop
// count, stop lookup, channel multiply, sum and round. One transaction is
// accepted per clock while req_stall is low; the multiply stage holds two
// products per channel, 8 x (FRAC_BITS+1) and 8 x FRAC_BITS bits.
// When rsp_stall is high, the response holds and the stages behind it keep
// filling bubbles; req_stall rises only once all five stages are occupied.
// Reset clears all stage valid bits and selects the red palette.
`default_nettype none

`include "palette_gradient_color_map_core_macros.svh"

module palette_gradient_color_map_core #(
   parameter int FRAC_BITS = pgcm_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [pgcm_pkg::POS_WIDTH-1:0] req_position,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [pgcm_pkg::CHAN_WIDTH-1:0] rsp_red,
   output logic             [pgcm_pkg::CHAN_WIDTH-1:0] rsp_green,
   output logic             [pgcm_pkg::CHAN_WIDTH-1:0] rsp_blue,
   input  wire logic                                  csr_wr_en,
   input  wire logic        [pgcm_pkg::PAL_WIDTH-1:0]  csr_wr_data
);
   import pgcm_pkg::*;

   localparam int PW = FRAC_BITS + 1;
   localparam int FW = FRAC_BITS + IDX_WIDTH;
   localparam int CW = (FRAC_BITS + 1 > POS_WIDTH - 1) ? FRAC_BITS + 1 : POS_WIDTH - 1;

   // Stage valid bits and ready chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic [PAL_WIDTH-1:0] palette_ff;

   logic [CW-1:0]        raw_ext, one_ext, pos_clamp;
   logic [PW-1:0]        s1_pos_ff;
   logic [PAL_WIDTH-1:0] s1_pal_ff;

   logic [FW-1:0]        s2_f_in, s2_f_ff;
   logic [PAL_WIDTH-1:0] s2_pal_ff;

   logic [IDX_WIDTH-1:0]    last, idx_raw, idx, nxt;
   logic [FRAC_BITS-1:0]    frac_in;
   logic [3*CHAN_WIDTH-1:0] s3_a_ff, s3_b_ff;
   logic [FRAC_BITS-1:0]    s3_frac_ff;

   pgcm_adv_type adv;

   // Ready chain: a stage loads when it is empty or its contents move on
   always_comb begin
      rdy5 = !s5_valid_ff || !rsp_stall;
      rdy4 = !s4_valid_ff || rdy5;
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
   end

   assign req_stall  = !rdy1;
   assign rsp_valid  = s5_valid_ff;
   assign adv.mul_en = rdy4;
   assign adv.sum_en = rdy5;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
         if (rdy5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Palette register
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= PAL_RED;
      end else if (csr_wr_en) begin
         palette_ff <= csr_wr_data;
      end
   end

   // Stage 1: clamp the position to 0..1.0
   always_comb begin
      raw_ext = CW'(req_position[POS_WIDTH-2:0]);
      one_ext = CW'(1) << FRAC_BITS;
      if (req_position[POS_WIDTH-1]) begin
         pos_clamp = '0;
      end else if (raw_ext > one_ext) begin
         pos_clamp = one_ext;
      end else begin
         pos_clamp = raw_ext;
      end
   end

   // Stage 2: scale by the stop count minus one (two or five)
   always_comb begin
      if (s1_pal_ff == PAL_RAINBOW) begin
         s2_f_in = (FW'(s1_pos_ff) << 2) + FW'(s1_pos_ff);
      end else begin
         s2_f_in = FW'(s1_pos_ff) << 1;
      end
   end

   // Stage 3: split into stop index and fraction, saturate at the last stop
   always_comb begin
      last    = pal_last(s2_pal_ff);
      idx_raw = s2_f_ff[FRAC_BITS +: IDX_WIDTH];
      if (idx_raw >= last) begin
         idx     = last;
         frac_in = '0;
         nxt     = last;
      end else begin
         idx     = idx_raw;
         frac_in = s2_f_ff[FRAC_BITS-1:0];
         nxt     = idx_raw + 3'd1;
      end
   end

   // Hold payload per stage
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_pos_ff <= PW'(pos_clamp);
         s1_pal_ff <= pal_resolve(palette_ff);
      end
      if (rdy2) begin
         s2_f_ff   <= s2_f_in;
         s2_pal_ff <= s1_pal_ff;
      end
      if (rdy3) begin
         s3_a_ff    <= stop_color(s2_pal_ff, idx);
         s3_b_ff    <= stop_color(s2_pal_ff, nxt);
         s3_frac_ff <= frac_in;
      end
   end

   // Stages 4 and 5: blend each channel
   pgcm_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_red (
      .clock  (clock),
      .adv    (adv),
      .stop_a (s3_a_ff[2*CHAN_WIDTH +: CHAN_WIDTH]),
      .stop_b (s3_b_ff[2*CHAN_WIDTH +: CHAN_WIDTH]),
      .frac   (s3_frac_ff),
      .chan   (rsp_red)
   );

   pgcm_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_green (
      .clock  (clock),
      .adv    (adv),
      .stop_a (s3_a_ff[CHAN_WIDTH +: CHAN_WIDTH]),
      .stop_b (s3_b_ff[CHAN_WIDTH +: CHAN_WIDTH]),
      .frac   (s3_frac_ff),
      .chan   (rsp_green)
   );

   pgcm_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_blue (
      .clock  (clock),
      .adv    (adv),
      .stop_a (s3_a_ff[0 +: CHAN_WIDTH]),
      .stop_b (s3_b_ff[0 +: CHAN_WIDTH]),
      .frac   (s3_frac_ff),
      .chan   (rsp_blue)
   );

   // Checks
   `PGCM_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff && rsp_stall,
      "request stalled while the pipeline has a free stage")
   `PGCM_ASSERT_NOW(a_scaled_in_range, clock, reset, s2_valid_ff,
      s2_f_ff[FRAC_BITS +: IDX_WIDTH] <= pal_last(s2_pal_ff),
      "scaled position beyond the last stop")
   `PGCM_ASSERT_NEXT(a_item_moves_on, clock, reset, s4_valid_ff && rdy5,
      s5_valid_ff, "item lost between multiply and sum stages")

endmodule

`default_nettype wire

@@ tb/palette_gradient_color_map_core_tb.sv @@
`timescale 1ns / 1ps

module palette_gradient_color_map_core_tb;
   import pgcm_pkg::*;

   localparam int FRAC_BITS     = FRAC_BITS_DEFAULT;
   localparam int UNIT_POS      = 1 << FRAC_BITS;
   localparam int PHASE_ITEMS   = 32;
   localparam int PHASE_COUNT   = 16;
   localparam int IDLE_SPLIT    = 180;
   localparam int HOLD_CYCLES   = 48;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 10;

   typedef logic signed [POS_WIDTH-1:0] position_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } color_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   position_type          req_position = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [CHAN_WIDTH-1:0] rsp_red;
   logic [CHAN_WIDTH-1:0] rsp_green;
   logic [CHAN_WIDTH-1:0] rsp_blue;
   logic                  csr_wr_en    = 1'b0;
   logic [PAL_WIDTH-1:0]  csr_wr_data  = '0;

   // Testbench view of the palette register, tracks every write
   logic [PAL_WIDTH-1:0]  palette_now  = PAL_RED;

   position_type position_q[$];
   color_type    color_expect_q[$];

   int  fail_count  = 0;
   int  req_count   = 0;
   int  rsp_count   = 0;
   int  quiet_count = 0;
   bit  req_taken   = 1'b0;
   bit  run_done    = 1'b0;
   int  hold_left   = 0;
   int  next_hold   = 60;

   palette_gradient_color_map_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Stop colors of one palette as {red, green, blue}, first stop leftmost
   function automatic logic [0:5][23:0] palette_stops(input logic [PAL_WIDTH-1:0] pal);
      logic [0:5][23:0] row;
      case (pal)
         PAL_BLUE: begin
            row = {{8'd40, 8'd60, 8'd200}, {8'd60, 8'd120, 8'd255},
                   {8'd20, 8'd30, 8'd140}, 72'd0};
         end
         PAL_ORANGE: begin
            row = {{8'd255, 8'd120, 8'd40}, {8'd255, 8'd160, 8'd60},
                   {8'd220, 8'd90, 8'd20}, 72'd0};
         end
         PAL_GREEN: begin
            row = {{8'd30, 8'd180, 8'd90}, {8'd60, 8'd220, 8'd140},
                   {8'd20, 8'd120, 8'd60}, 72'd0};
         end
         PAL_PURPLE: begin
            row = {{8'd160, 8'd60, 8'd220}, {8'd200, 8'd120, 8'd255},
                   {8'd100, 8'd40, 8'd180}, 72'd0};
         end
         PAL_RAINBOW: begin
            row = {{8'd255, 8'd50, 8'd50}, {8'd255, 8'd150, 8'd50},
                   {8'd255, 8'd255, 8'd50}, {8'd50, 8'd255, 8'd50},
                   {8'd50, 8'd150, 8'd255}, {8'd160, 8'd50, 8'd255}};
         end
         default: begin
            row = {{8'd220, 8'd40, 8'd50}, {8'd255, 8'd60, 8'd60},
                   {8'd200, 8'd20, 8'd30}, 72'd0};
         end
      endcase
      return row;
   endfunction

   // Linear blend of two channel values, rounded half up
   function automatic logic [CHAN_WIDTH-1:0] mix_channel(input int unsigned a,
                                                         input int unsigned b,
                                                         input int unsigned t);
      longint unsigned acc;
      acc = longint'(a) * (UNIT_POS - t) + longint'(b) * t + (UNIT_POS >> 1);
      return acc[FRAC_BITS +: CHAN_WIDTH];
   endfunction

   // Expected color for one position under the given palette code
   function automatic color_type predict_color(input logic [PAL_WIDTH-1:0] pal_code,
                                               input position_type pos_in);
      logic [PAL_WIDTH-1:0] pal;
      logic [0:5][23:0]     stops;
      int unsigned          last, pos, scaled, idx, frac, nxt;
      color_type            c;
      pal   = (pal_code > PAL_RAINBOW) ? PAL_RED : pal_code;
      last  = (pal == PAL_RAINBOW) ? 5 : 2;
      stops = palette_stops(pal);
      // Clamp to 0..1.0
      if (pos_in < 0)
         pos = 0;
      else if (pos_in > UNIT_POS)
         pos = UNIT_POS;
      else
         pos = pos_in;
      scaled = pos * last;
      idx    = scaled >> FRAC_BITS;
      frac   = scaled & (UNIT_POS - 1);
      // Saturate at the last stop
      if (idx >= last) begin
         idx  = last;
         frac = 0;
      end
      nxt = (idx < last) ? idx + 1 : idx;
      c.red   = mix_channel(stops[idx][23:16], stops[nxt][23:16], frac);
      c.green = mix_channel(stops[idx][15:8],  stops[nxt][15:8],  frac);
      c.blue  = mix_channel(stops[idx][7:0],   stops[nxt][7:0],   frac);
      return c;
   endfunction

   // Idle share in percent for the sender or the receiver, by run phase
   function automatic int idle_pct(input bit sender);
      if (req_count < IDLE_SPLIT)
         return sender ? 34 : 81;
      else if (req_count < 2 * IDLE_SPLIT)
         return sender ? 81 : 34;
      return 0;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
      fail_count++;
   endtask

   // Wait until every queued transaction has gone through
   task automatic drain_pipe();
      while (position_q.size() != 0 || color_expect_q.size() != 0)
         @(posedge clock);
   endtask

   // Write the palette register while the block is idle
   task automatic apply_palette(input logic [PAL_WIDTH-1:0] code);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      palette_now = code;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Request side: record accepted transactions and predict their colors
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         color_expect_q.push_back(predict_color(palette_now, req_position));
         void'(position_q.pop_front());
         req_count++;
      end
   end

   // Request side: offer the next position, hold a stalled one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (position_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
         req_valid    <= 1'b1;
         req_position <= position_q[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response side: random stalls plus long hold-offs to back up the pipe
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_count >= next_hold) begin
         hold_left = HOLD_CYCLES;
         next_hold = (next_hold == 60) ? 420 : 32'h7fffffff;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b0));
      end
   end

   // Response side: compare each transaction with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      color_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (color_expect_q.size() == 0) begin
            report_mismatch("unexpected response", 0, 1);
         end else begin
            want = color_expect_q.pop_front();
            if (rsp_red !== want.red)
               report_mismatch("red", want.red, rsp_red);
            if (rsp_green !== want.green)
               report_mismatch("green", want.green, rsp_green);
            if (rsp_blue !== want.blue)
               report_mismatch("blue", want.blue, rsp_blue);
         end
         rsp_count++;
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || run_done || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int                   kind;
      position_type         p;
      logic [PAL_WIDTH-1:0] code;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: red palette from reset, clamps and stop boundaries
      position_q.push_back(position_type'(-131072));
      position_q.push_back(position_type'(-1));
      position_q.push_back(position_type'(0));
      position_q.push_back(position_type'(1));
      position_q.push_back(position_type'(32767));
      position_q.push_back(position_type'(32768));
      position_q.push_back(position_type'(65535));
      position_q.push_back(position_type'(65536));
      position_q.push_back(position_type'(65537));
      position_q.push_back(position_type'(98304));
      position_q.push_back(position_type'(131071));
      drain_pipe();

      // Directed: rainbow, around each of its stop boundaries
      apply_palette(PAL_RAINBOW);
      position_q.push_back(position_type'(0));
      position_q.push_back(position_type'(6554));
      position_q.push_back(position_type'(13107));
      position_q.push_back(position_type'(13108));
      position_q.push_back(position_type'(26214));
      position_q.push_back(position_type'(39321));
      position_q.push_back(position_type'(52428));
      position_q.push_back(position_type'(52429));
      position_q.push_back(position_type'(65535));
      position_q.push_back(position_type'(65536));
      position_q.push_back(position_type'(-65536));
      position_q.push_back(position_type'(131071));
      drain_pipe();

      // Random phases: every palette code once, then random codes
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         code = (ph < 8) ? PAL_WIDTH'(ph) : PAL_WIDTH'($urandom_range(0, 7));
         apply_palette(code);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = $urandom_range(99);
            if (kind < 60)
               p = position_type'($urandom_range(0, UNIT_POS));
            else if (kind < 70)
               p = ($urandom_range(1)) ? position_type'(UNIT_POS - $urandom_range(0, 3))
                                       : position_type'($urandom_range(0, 3));
            else if (kind < 80)
               p = position_type'(UNIT_POS + $urandom_range(1, 131071 - UNIT_POS));
            else
               p = position_type'($urandom);
            position_q.push_back(p);
         end
         drain_pipe();
      end

      run_done = 1'b1;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && color_expect_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
